@@ sv/ngh_pkg.sv @@
package ngh_pkg;

   // controller states: idle, multiplier rebuild sequence, query sequence
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RB_LAST,
      ST_RB_IDX,
      ST_RB_ADD,
      ST_RB_MOD,
      ST_RB_MUL,
      ST_RB_WR,
      ST_QUERY
   } ngh_state_type;

   localparam int NUM_OFFSETS  = 4;
   localparam int OFF_IDX_W    = $clog2(NUM_OFFSETS);
   localparam int PRIME_COUNT  = 36;
   localparam int OFFSET_W     = 5;
   localparam int COUNT_W      = 3;
   localparam int HASH_W       = 64;
   localparam int REQ_TDATA_W  = 120;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 5;

   // request kinds carried on tuser
   localparam logic REQ_STORE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTEXT_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_FIRST  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_LAST   = 3'd4;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET [NUM_OFFSETS] =
      '{5'h1F, 5'h1E, 5'h1D, 5'h1C};

   localparam logic [63:0] BASE_FULL    = 64'd108641969 * 64'd116049371;
   localparam logic [31:0] BASE_PRODUCT = BASE_FULL[31:0];

   function automatic logic [31:0] prime_at(input logic [5:0] i);
      logic [31:0] p;
      case (i)
         6'd0:  p = 32'd108641969;
         6'd1:  p = 32'd116049371;
         6'd2:  p = 32'd125925907;
         6'd3:  p = 32'd133333309;
         6'd4:  p = 32'd145678979;
         6'd5:  p = 32'd175308587;
         6'd6:  p = 32'd197530793;
         6'd7:  p = 32'd234567803;
         6'd8:  p = 32'd251851741;
         6'd9:  p = 32'd264197411;
         6'd10: p = 32'd330864029;
         6'd11: p = 32'd399999781;
         6'd12: p = 32'd407407183;
         6'd13: p = 32'd459258997;
         6'd14: p = 32'd479012069;
         6'd15: p = 32'd545678687;
         6'd16: p = 32'd560493491;
         6'd17: p = 32'd607407037;
         6'd18: p = 32'd629629243;
         6'd19: p = 32'd656789717;
         6'd20: p = 32'd716048933;
         6'd21: p = 32'd718518067;
         6'd22: p = 32'd725925469;
         6'd23: p = 32'd733332871;
         6'd24: p = 32'd753085943;
         6'd25: p = 32'd755555077;
         6'd26: p = 32'd782715551;
         6'd27: p = 32'd790122953;
         6'd28: p = 32'd812345159;
         6'd29: p = 32'd814814293;
         6'd30: p = 32'd893826581;
         6'd31: p = 32'd923456189;
         6'd32: p = 32'd940740127;
         6'd33: p = 32'd953085797;
         6'd34: p = 32'd985184539;
         6'd35: p = 32'd990122807;
         default: p = 32'd0;
      endcase
      return p;
   endfunction

   // 5-bit offset, sign-extended to 32 bits, modulo 36 (2^32 mod 36 = 4)
   function automatic logic [5:0] offset_mod36(input logic [OFFSET_W-1:0] r);
      logic [5:0] v;
      if (!r[4]) begin
         v = {2'b00, r[3:0]};
      end else if (r >= 5'd28) begin
         v = 6'({1'b0, r} - 6'd28);
      end else begin
         v = 6'({1'b0, r} + 6'd8);
      end
      return v;
   endfunction

   // 32-bit value modulo 36: x = 4q + x[1:0], so x mod 36 = 4*(q mod 9) + x[1:0].
   // q mod 9 by folding 6-bit chunks (64 = 1 mod 9), then 8 = -1 mod 9.
   function automatic logic [5:0] word_mod36(input logic [31:0] x);
      logic [29:0] q;
      logic [8:0]  s;
      logic [6:0]  t;
      logic [5:0]  u;
      logic [4:0]  v;
      logic [3:0]  r9;
      q  = x[31:2];
      s  = 9'(q[5:0]) + 9'(q[11:6]) + 9'(q[17:12]) + 9'(q[23:18]) + 9'(q[29:24]);
      t  = 7'(s[5:0]) + 7'(s[8:6]);
      u  = t[5:0] + 6'(t[6]);
      v  = 5'(u[2:0]) + 5'd9 - 5'(u[5:3]);
      r9 = (v >= 5'd9) ? 4'(v - 5'd9) : v[3:0];
      return {r9, x[1:0]};
   endfunction

endpackage

@@ sv/ngram_context_hash.sv @@
// Channel  Dir  Beat fields (low bit up)
// req      in   tdata: word_pos[7:0] word_id[31:8] target_pos[39:32]
//                      sentence_length[48:40] seed_value[112:49], pad to 120
//               tuser: req_type (0 store, 1 query)
// rsp      out  tdata: hash_value[63:0], one beat per query beat
// csr      in   wen / index / wdata, 0 = context_count, 1..4 = offset_0..3
//
// Store beat: one write to the sentence memory.
// Query beat: built by one shared 32x32 multiplier and one sentence memory
//   read per active offset; the next beat is taken once the result has
//   moved into the output register.
// Reset (synchronous) and every register write start a multiplier rebuild
//   (RB_LAST, then RB_IDX..RB_WR per active offset) with req_tready low.
// A result waits in rsp_tdata while store beats keep flowing; a query
//   that finishes into a full output register holds until it drains.
module ngram_context_hash
   import ngh_pkg::*;
#(
   parameter int MAX_CONTEXT  = 4,
   parameter int MAX_SENTENCE = 256,
   parameter int WORD_BITS    = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // word_pos, word_id, target_pos,
                                               // sentence_length, seed_value
   input  logic                   req_tuser,   // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [HASH_W-1:0]      rsp_tdata,   // hash_value
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW  = (MAX_SENTENCE > 1) ? $clog2(MAX_SENTENCE) : 1;
   localparam int LW  = 14;
   localparam int CAP = (MAX_CONTEXT < NUM_OFFSETS) ? MAX_CONTEXT : NUM_OFFSETS;
   localparam logic [LW-1:0]      SENT_MAX  = LW'(MAX_SENTENCE);
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP);

   // request fields
   logic [7:0]  req_word_pos;
   logic [23:0] req_word_id;
   logic [7:0]  req_target_pos;
   logic [8:0]  req_sentence_length;
   logic [63:0] req_seed_value;

   assign req_word_pos        = req_tdata[7:0];
   assign req_word_id         = req_tdata[31:8];
   assign req_target_pos      = req_tdata[39:32];
   assign req_sentence_length = req_tdata[48:40];
   assign req_seed_value      = req_tdata[112:49];

   // config
   logic [COUNT_W-1:0]  count_ff;
   logic [OFFSET_W-1:0] offset_ff [NUM_OFFSETS];
   logic [COUNT_W-1:0]  active_n;
   logic                csr_hit;

   // control
   ngh_state_type state_ff, state_in;
   logic          req_ready_c;
   logic          final_go;
   logic          req_accept;

   // rebuild datapath
   logic [OFF_IDX_W-1:0] oidx_ff;
   logic [OFFSET_W-1:0]  last_ff;
   logic [31:0]          chain_ff;
   logic [31:0]          idx_ff;
   logic [5:0]           rem_ff;
   logic [31:0]          mult_ff [NUM_OFFSETS];

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic        mul_en;
   logic [63:0] prod_ff;

   // query datapath
   logic [2:0]           step_ff;
   logic [7:0]           tgt_ff;
   logic [8:0]           len_ff;
   logic [63:0]          seed_ff;
   logic [63:0]          acc_ff;
   logic                 term_hi_ff;
   logic                 term_keep_ff;
   logic                 in_ff;
   logic [63:0]          term;
   logic [2:0]           wsel;
   logic [2:0]           last_mul_step;
   logic [2:0]           final_step;

   // offset select (single read point)
   logic [OFF_IDX_W-1:0] off_sel_idx;
   logic [OFFSET_W-1:0]  off_sel;
   logic [31:0]          off32;
   logic [2:0]           step_m1;
   logic [COUNT_W-1:0]   n_m1;

   // sentence memory
   logic [WORD_BITS-1:0] sentence_mem [MAX_SENTENCE];
   logic [WORD_BITS-1:0] rd_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 pos_in;
   logic signed [10:0]   pos;
   logic [LW-1:0]        len_eff;
   logic                 st_en;

   // ---------------------------------------------------------------
   // active offset count: 0 acts as 1, saturate at 4 and MAX_CONTEXT
   always_comb begin
      if (count_ff == '0) begin
         active_n = COUNT_W'(1);
      end else if (count_ff > COUNT_CAP) begin
         active_n = COUNT_CAP;
      end else begin
         active_n = count_ff;
      end
   end

   assign csr_hit       = csr_wen && (csr_index <= CSR_OFFSET_LAST);
   assign n_m1          = active_n - COUNT_W'(1);
   assign last_mul_step = 3'(active_n) + 3'd1;
   assign final_step    = 3'(active_n) + 3'd2;
   assign step_m1       = step_ff - 3'd1;
   assign wsel          = step_ff - 3'd2;

   // ---------------------------------------------------------------
   // next state
   always_comb begin
      state_in    = state_ff;
      req_ready_c = 1'b0;
      final_go    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready_c = !csr_wen;
            if (req_tvalid && !csr_wen && (req_tuser == REQ_QUERY)) begin
               state_in = ST_QUERY;
            end
         end
         ST_RB_LAST: state_in = ST_RB_IDX;
         ST_RB_IDX:  state_in = ST_RB_ADD;
         ST_RB_ADD:  state_in = ST_RB_MOD;
         ST_RB_MOD:  state_in = ST_RB_MUL;
         ST_RB_MUL:  state_in = ST_RB_WR;
         ST_RB_WR: begin
            if (COUNT_W'(oidx_ff) == n_m1) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RB_IDX;
            end
         end
         ST_QUERY: begin
            if ((step_ff == final_step) && (!rsp_tvalid || rsp_tready)) begin
               final_go = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a register write restarts the rebuild
      if (csr_hit) begin
         state_in = ST_RB_LAST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RB_LAST;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = req_ready_c;
   assign req_accept = req_tvalid && req_ready_c;

   // ---------------------------------------------------------------
   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         for (int i = 0; i < NUM_OFFSETS; i++) begin
            offset_ff[i] <= OFFSET_RESET[i];
         end
      end else if (csr_wen) begin
         if (csr_index == CSR_CONTEXT_COUNT) begin
            count_ff <= csr_wdata[COUNT_W-1:0];
         end else if (csr_index <= CSR_OFFSET_LAST) begin
            offset_ff[OFF_IDX_W'(csr_index - CSR_OFFSET_FIRST)] <= csr_wdata;
         end
      end
   end

   // one offset read per cycle: last active during RB_LAST, the read
   // slot during a query, the rebuild index otherwise
   always_comb begin
      case (state_ff)
         ST_RB_LAST: off_sel_idx = n_m1[OFF_IDX_W-1:0];
         ST_QUERY:   off_sel_idx = step_m1[OFF_IDX_W-1:0];
         default:    off_sel_idx = oidx_ff;
      endcase
   end

   assign off_sel = offset_ff[off_sel_idx];
   assign off32   = {{(32-OFFSET_W){off_sel[OFFSET_W-1]}}, off_sel};

   // ---------------------------------------------------------------
   // shared multiplier operand select
   always_comb begin
      mul_a  = 32'd0;
      mul_b  = 32'd0;
      mul_en = 1'b0;
      case (state_ff)
         ST_RB_IDX: begin
            mul_a  = {{(32-OFFSET_W){last_ff[OFFSET_W-1]}}, last_ff};
            mul_b  = prime_at(offset_mod36(off_sel));
            mul_en = 1'b1;
         end
         ST_RB_MUL: begin
            mul_a  = prime_at(rem_ff);
            mul_b  = (oidx_ff == '0) ? BASE_PRODUCT : chain_ff;
            mul_en = 1'b1;
         end
         ST_QUERY: begin
            if (step_ff == 3'd0) begin
               mul_a  = BASE_PRODUCT;
               mul_b  = seed_ff[31:0];
               mul_en = 1'b1;
            end else if (step_ff == 3'd1) begin
               mul_a  = BASE_PRODUCT;
               mul_b  = seed_ff[63:32];
               mul_en = 1'b1;
            end else if (step_ff <= last_mul_step) begin
               mul_a  = mult_ff[wsel[OFF_IDX_W-1:0]];
               mul_b  = 32'(rd_ff) + 32'd1;
               mul_en = 1'b1;
            end
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= {32'd0, mul_a} * {32'd0, mul_b};
      end
   end

   // ---------------------------------------------------------------
   // multiplier rebuild: idx = last*P[off%36] + off, m = P[idx%36]*prev
   always_ff @(posedge clock) begin
      if (reset) begin
         oidx_ff <= '0;
      end else if (state_ff == ST_RB_LAST) begin
         oidx_ff <= '0;
      end else if ((state_ff == ST_RB_WR) && (state_in == ST_RB_IDX)) begin
         oidx_ff <= oidx_ff + OFF_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_RB_LAST: begin
            last_ff <= off_sel;
         end
         ST_RB_ADD: begin
            idx_ff <= prod_ff[31:0] + off32;
         end
         ST_RB_MOD: begin
            rem_ff <= word_mod36(idx_ff);
         end
         ST_RB_WR: begin
            mult_ff[oidx_ff] <= prod_ff[31:0];
            chain_ff         <= prod_ff[31:0];
         end
         default: begin
            chain_ff <= chain_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // query sequence
   // step 0: base*seed_lo, step 1: base*seed_hi, step k+2: mult[k]*(w+1)
   // read for offset k issues at step k+1; each term accumulates in the step after its multiply
   assign len_eff = (LW'(len_ff) > SENT_MAX) ? SENT_MAX : LW'(len_ff);
   assign pos     = $signed({3'b000, tgt_ff}) + $signed({{6{off_sel[4]}}, off_sel});
   assign pos_in  = !pos[10] && (LW'(pos[9:0]) < len_eff);
   assign rd_addr = AW'(pos[9:0]);
   assign rd_en   = (state_ff == ST_QUERY) && (step_ff >= 3'd1) &&
                    (step_ff <= 3'(active_n));

   always_comb begin
      if (term_hi_ff) begin
         term = {prod_ff[31:0], 32'd0};
      end else if (term_keep_ff) begin
         term = prod_ff;
      end else begin
         term = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_tuser == REQ_QUERY)) begin
         tgt_ff  <= req_target_pos;
         len_ff  <= req_sentence_length;
         seed_ff <= req_seed_value;
         acc_ff  <= 64'd0;
      end else if ((state_ff == ST_QUERY) && (step_ff >= 3'd1) &&
                   (step_ff <= last_mul_step)) begin
         acc_ff <= acc_ff + term;
      end
      if (rd_en) begin
         in_ff <= pos_in;
      end
      if ((state_ff == ST_QUERY) && mul_en) begin
         term_hi_ff   <= (step_ff == 3'd1);
         term_keep_ff <= (step_ff < 3'd2) ? 1'b1 : in_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (state_ff != ST_QUERY) begin
         step_ff <= '0;
      end else if (step_ff != final_step) begin
         step_ff <= step_ff + 3'd1;
      end
   end

   // ---------------------------------------------------------------
   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (final_go) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (final_go) begin
         rsp_tdata <= acc_ff + term;
      end
   end

   // ---------------------------------------------------------------
   // sentence memory: one write (store beat), one registered read (query)
   assign st_en = req_accept && (req_tuser == REQ_STORE) &&
                  (LW'(req_word_pos) < SENT_MAX);

   always_ff @(posedge clock) begin
      if (st_en) begin
         sentence_mem[AW'(req_word_pos)] <= WORD_BITS'(req_word_id);
      end
      if (rd_en) begin
         rd_ff <= sentence_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------
   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == REQ_QUERY))
      |=> (state_ff == ST_QUERY) && (step_ff == 3'd0))
      else $error("query accept did not start the query sequence");

   a_csr_rebuild: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (state_ff == ST_RB_LAST))
      else $error("register write did not restart the rebuild");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RB_MUL) |-> (rem_ff < 6'(PRIME_COUNT)))
      else $error("modulo remainder out of range");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUERY) |-> (step_ff <= final_step))
      else $error("query step past final step");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !final_go)
      else $error("result overwrote an undelivered beat");

endmodule
